/* hdl/field_relative_drive_vector_unit_defines.svh */
// ---------------------------------------------------------------------------
// Field-relative drive vector: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FIELD_RELATIVE_DRIVE_VECTOR_UNIT_DEFINES_SVH
`define FIELD_RELATIVE_DRIVE_VECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fdv_pkg.sv */
// ---------------------------------------------------------------------------
// fdv_pkg
// Widths, angle constants, arctangent table and stage payload type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdv_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int HEAD_W        = 24;
  localparam int SPEED_W       = 16;
  localparam int DIR_W         = 13;
  localparam int IN_W          = ((2 * SAMPLE_BITS + HEAD_W + 7) / 8) * 8;
  localparam int OUT_W         = ((SPEED_W + DIR_W + 7) / 8) * 8;

  // angles in 1/16 degree
  localparam int FULL_TURN    = 5760;
  localparam int HALF_TURN    = 2880;
  localparam int QUARTER_TURN = 1440;
  localparam int ANGLE_W      = 13;

  localparam int WORK_SHIFT = 16;
  localparam int TABLE_LEN  = 24;
  localparam int ROUND_BIAS = 2 ** (WORK_SHIFT - 1);

  localparam int CORDIC_USED = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int CW          = SAMPLE_BITS + WORK_SHIFT + 3;
  localparam int ZW          = 30;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int RW          = SAMPLE_BITS + 2;

  // heading: bias to a non-negative multiple of a turn, then binary reduction
  localparam int HEAD_BIAS  = ((2 ** (HEAD_W - 1) + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int HEAD_U_W   = HEAD_W + 1;
  localparam int MOD_STEPS  = 12;

  localparam int ITER_A  = (CORDIC_USED > SAMPLE_BITS) ? CORDIC_USED : SAMPLE_BITS;
  localparam int N_ITER  = (ITER_A > MOD_STEPS) ? ITER_A : MOD_STEPS;

  localparam logic [ANGLE_W-1:0] ANG_0   = '0;
  localparam logic [ANGLE_W-1:0] ANG_90  = ANGLE_W'(QUARTER_TURN);
  localparam logic [ANGLE_W-1:0] ANG_180 = ANGLE_W'(2 * QUARTER_TURN);
  localparam logic [ANGLE_W-1:0] ANG_270 = ANGLE_W'(3 * QUARTER_TURN);

  typedef struct packed {
    logic signed [CW-1:0]   a;
    logic signed [CW-1:0]   b;
    logic signed [ZW-1:0]   z;
    logic [SQ_W-1:0]        sq;
    logic [RW-1:0]          rem;
    logic [SAMPLE_BITS-1:0] root;
    logic [HEAD_U_W-1:0]    hu;
    logic [ANGLE_W-1:0]     base;
    logic                   axis;
  } iter_t;

  // atan(2^-i) in 1/16 degree * 2^-16
  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = ZW'(47185920);
      1:  v = ZW'(27855475);
      2:  v = ZW'(14718068);
      3:  v = ZW'(7471121);
      4:  v = ZW'(3750058);
      5:  v = ZW'(1876857);
      6:  v = ZW'(938658);
      7:  v = ZW'(469357);
      8:  v = ZW'(234682);
      9:  v = ZW'(117342);
      10: v = ZW'(58671);
      11: v = ZW'(29335);
      12: v = ZW'(14668);
      13: v = ZW'(7334);
      14: v = ZW'(3667);
      15: v = ZW'(1833);
      16: v = ZW'(917);
      17: v = ZW'(458);
      18: v = ZW'(229);
      19: v = ZW'(115);
      20: v = ZW'(57);
      21: v = ZW'(29);
      22: v = ZW'(14);
      23: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/fdv_front.sv */
// ---------------------------------------------------------------------------
// fdv_front
// Quadrant decode, magnitudes, squares and iteration seed (three stages).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdv_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire logic                                in_vld,
  input  wire logic signed [fdv_pkg::SAMPLE_BITS-1:0] stick_x,
  input  wire logic signed [fdv_pkg::SAMPLE_BITS-1:0] stick_y_raw,
  input  wire logic signed [fdv_pkg::HEAD_W-1:0]   heading,
  output logic                                     out_vld,
  output fdv_pkg::iter_t                           out_data
);
  import fdv_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ux;
    logic [SAMPLE_BITS-1:0] uy;
    logic [SAMPLE_BITS-1:0] p;
    logic [SAMPLE_BITS-1:0] q;
    logic [HEAD_U_W-1:0]    hu;
    logic [ANGLE_W-1:0]     base;
    logic                   axis;
  } st1_t;

  typedef struct packed {
    logic [SQ_W-1:0]        sqx;
    logic [SQ_W-1:0]        sqy;
    logic [SAMPLE_BITS-1:0] p;
    logic [SAMPLE_BITS-1:0] q;
    logic [HEAD_U_W-1:0]    hu;
    logic [ANGLE_W-1:0]     base;
    logic                   axis;
  } st2_t;

  st1_t st1, st1_next;
  st2_t st2, st2_next;
  iter_t seed_next;
  logic vld1, vld2;

  logic [SAMPLE_BITS-1:0] ux, uy;
  logic x_pos, x_neg, y_up, y_dn;

  assign ux = stick_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(~stick_x + 1'b1) : SAMPLE_BITS'(stick_x);
  assign uy = stick_y_raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~stick_y_raw + 1'b1)
                                         : SAMPLE_BITS'(stick_y_raw);
  assign x_neg = stick_x[SAMPLE_BITS-1];
  assign x_pos = !stick_x[SAMPLE_BITS-1] && (stick_x != '0);
  // y is negated: raw negative means stick up
  assign y_up  = stick_y_raw[SAMPLE_BITS-1];
  assign y_dn  = !stick_y_raw[SAMPLE_BITS-1] && (stick_y_raw != '0);

  always_comb begin
    st1_next      = '0;
    st1_next.ux   = ux;
    st1_next.uy   = uy;
    st1_next.hu   = {heading[HEAD_W-1], heading} + HEAD_U_W'(HEAD_BIAS);
    priority if (x_pos && y_up) begin
      st1_next.p = uy; st1_next.q = ux; st1_next.base = ANG_0;
    end else if (x_pos && y_dn) begin
      st1_next.p = ux; st1_next.q = uy; st1_next.base = ANG_90;
    end else if (x_neg && y_dn) begin
      st1_next.p = uy; st1_next.q = ux; st1_next.base = ANG_180;
    end else if (x_neg && y_up) begin
      st1_next.p = ux; st1_next.q = uy; st1_next.base = ANG_270;
    end else if (y_up) begin
      st1_next.axis = 1'b1; st1_next.base = ANG_0;
    end else if (x_pos) begin
      st1_next.axis = 1'b1; st1_next.base = ANG_90;
    end else if (y_dn) begin
      st1_next.axis = 1'b1; st1_next.base = ANG_180;
    end else if (x_neg) begin
      st1_next.axis = 1'b1; st1_next.base = ANG_270;
    end else begin
      st1_next.axis = 1'b1; st1_next.base = ANG_0;
    end
  end

  always_comb begin
    st2_next.sqx  = SQ_W'(st1.ux) * SQ_W'(st1.ux);
    st2_next.sqy  = SQ_W'(st1.uy) * SQ_W'(st1.uy);
    st2_next.p    = st1.p;
    st2_next.q    = st1.q;
    st2_next.hu   = st1.hu;
    st2_next.base = st1.base;
    st2_next.axis = st1.axis;
  end

  always_comb begin
    seed_next      = '0;
    seed_next.a    = $signed({{(CW-SAMPLE_BITS-WORK_SHIFT){1'b0}}, st2.p, {WORK_SHIFT{1'b0}}});
    seed_next.b    = $signed({{(CW-SAMPLE_BITS-WORK_SHIFT){1'b0}}, st2.q, {WORK_SHIFT{1'b0}}});
    seed_next.sq   = st2.sqx + st2.sqy;
    seed_next.hu   = st2.hu;
    seed_next.base = st2.base;
    seed_next.axis = st2.axis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (advance) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st1      <= st1_next;
      st2      <= st2_next;
      out_data <= seed_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/fdv_iter.sv */
// ---------------------------------------------------------------------------
// fdv_iter
// Iteration pipeline: per stage one CORDIC vectoring step and one square-root
// bit, plus one heading reduction step in each of the first MOD_STEPS stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdv_iter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           in_vld,
  input  fdv_pkg::iter_t      in_data,
  output logic                out_vld,
  output fdv_pkg::iter_t      out_data
);
  import fdv_pkg::*;

  iter_t stg_q [N_ITER];
  logic [N_ITER-1:0] vld;

  for (genvar gi = 0; gi < N_ITER; gi++) begin : g_stage
    localparam bit DO_CORDIC = (gi < CORDIC_USED);
    localparam bit DO_ROOT   = (gi < SAMPLE_BITS);
    localparam bit DO_MOD    = (gi < MOD_STEPS);
    localparam logic [HEAD_U_W-1:0] MOD_SUB =
      DO_MOD ? HEAD_U_W'(FULL_TURN * (2 ** (MOD_STEPS - 1 - gi))) : '0;

    iter_t src, nxt, q;
    logic signed [CW-1:0] da, db;
    logic [RW-1:0] rem_sh, trial;

    if (gi == 0) begin : g_first
      assign src = in_data;
    end else begin : g_rest
      assign src = stg_q[gi-1];
    end

    assign da     = src.b >>> gi;
    assign db     = src.a >>> gi;
    assign rem_sh = {src.rem[RW-3:0], src.sq[SQ_W-1 -: 2]};
    assign trial  = {src.root, 2'b01};

    always_comb begin
      nxt = src;
      if (DO_CORDIC) begin
        if (!src.b[CW-1]) begin
          nxt.a = src.a + da;
          nxt.b = src.b - db;
          nxt.z = src.z + atan_val(gi);
        end else begin
          nxt.a = src.a - da;
          nxt.b = src.b + db;
          nxt.z = src.z - atan_val(gi);
        end
      end
      if (DO_ROOT) begin
        nxt.sq = src.sq << 2;
        if (rem_sh >= trial) begin
          nxt.rem  = rem_sh - trial;
          nxt.root = {src.root[SAMPLE_BITS-2:0], 1'b1};
        end else begin
          nxt.rem  = rem_sh;
          nxt.root = {src.root[SAMPLE_BITS-2:0], 1'b0};
        end
      end
      if (DO_MOD) begin
        if (src.hu >= MOD_SUB) begin
          nxt.hu = src.hu - MOD_SUB;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        q <= nxt;
      end
    end

    assign stg_q[gi] = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[N_ITER-2:0], in_vld};
    end
  end

  assign out_vld  = vld[N_ITER-1];
  assign out_data = stg_q[N_ITER-1];

endmodule

`default_nettype wire

/* hdl/fdv_back.sv */
// ---------------------------------------------------------------------------
// fdv_back
// Angle rounding and quadrant assembly, speed rounding, heading difference
// and wrap (two stages, the second is the output register).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdv_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic                           in_vld,
  input  fdv_pkg::iter_t                      in_data,
  output logic                                out_vld,
  output logic [fdv_pkg::SPEED_W-1:0]         speed,
  output logic signed [fdv_pkg::DIR_W-1:0]    drive_dir
);
  import fdv_pkg::*;

  localparam int SPEED_MAX = 2 ** SPEED_W - 1;

  logic                   vld_a;
  logic [ANGLE_W-1:0]     hc, hc_next;
  logic [ANGLE_W-1:0]     comp, comp_next;
  logic [SPEED_W-1:0]     spd, spd_next;

  logic signed [ZW-1:0]   z_rnd, z_sh;
  logic [ANGLE_W-1:0]     z_clamp, c_sum;
  logic                   round_up;
  logic [SAMPLE_BITS:0]   spd_full;
  logic signed [ANGLE_W:0] diff, diff_next;

  // stage A: rounded quadrant angle, compass angle, rounded speed
  assign z_rnd = in_data.z + $signed(ZW'(ROUND_BIAS));
  assign z_sh  = z_rnd >>> WORK_SHIFT;

  always_comb begin
    if (in_data.axis || z_sh[ZW-1]) begin
      z_clamp = '0;
    end else if (z_sh > $signed(ZW'(QUARTER_TURN))) begin
      z_clamp = ANGLE_W'(QUARTER_TURN);
    end else begin
      z_clamp = z_sh[ANGLE_W-1:0];
    end
  end

  always_comb begin
    c_sum = in_data.base + z_clamp;
    if (c_sum >= ANGLE_W'(FULL_TURN)) begin
      comp_next = c_sum - ANGLE_W'(FULL_TURN);
    end else begin
      comp_next = c_sum;
    end
  end

  assign round_up = in_data.rem > {2'b00, in_data.root};
  assign spd_full = {1'b0, in_data.root} + (SAMPLE_BITS + 1)'(round_up);
  assign spd_next = (spd_full > (SAMPLE_BITS + 1)'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                               : SPEED_W'(spd_full);
  assign hc_next  = in_data.hu[ANGLE_W-1:0];

  // stage B: difference, wrapped into half a turn either way
  assign diff = $signed({1'b0, hc}) - $signed({1'b0, comp});

  always_comb begin
    if (diff > HALF_TURN) begin
      diff_next = diff - (ANGLE_W + 1)'(FULL_TURN);
    end else if (diff < -HALF_TURN) begin
      diff_next = diff + (ANGLE_W + 1)'(FULL_TURN);
    end else begin
      diff_next = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      out_vld <= 1'b0;
    end else if (advance) begin
      vld_a   <= in_vld;
      out_vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hc        <= hc_next;
      comp      <= comp_next;
      spd       <= spd_next;
      speed     <= spd;
      drive_dir <= diff_next[DIR_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/field_relative_drive_vector_unit.sv */
// ---------------------------------------------------------------------------
// field_relative_drive_vector_unit
// Joystick sample plus gyro heading in, stick speed and wheel direction out.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item per cycle: stick x, raw stick y (positive
//   down, negated inside) and the gyro heading in 1/16 degree.
//   m_* channel returns one item per input item, in order: the stick
//   magnitude (rounded square root of x^2 + y^2) and the wheel direction,
//   heading mod 360 minus stick compass angle, wrapped to +/-180 degrees.
//   The pipeline has three front stages (decode, squares, seed), one
//   iteration stage per CORDIC step / root bit and two back stages
//   ending in the output register.
//   Throughput is one item per cycle when not stalled; fully streaming.
//   When the receiver holds m_tready low with an item waiting, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready the cycle after.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "field_relative_drive_vector_unit_defines.svh"

module field_relative_drive_vector_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // [15:0] stick_x, [31:16] stick_y_raw, [55:32] heading
  input  wire logic [fdv_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [15:0] speed, [28:16] drive_dir, [31:29] zero
  output logic [fdv_pkg::OUT_W-1:0]       m_tdata
);
  import fdv_pkg::*;

  logic advance;
  logic front_vld, iter_vld;
  iter_t front_data, iter_data;
  logic [SPEED_W-1:0] speed_out;
  logic signed [DIR_W-1:0] wd_out;

  logic signed [SAMPLE_BITS-1:0] stick_x, stick_y_raw;
  logic signed [HEAD_W-1:0] heading;

  assign stick_x     = s_tdata[SAMPLE_BITS-1:0];
  assign stick_y_raw = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign heading     = s_tdata[2*SAMPLE_BITS+HEAD_W-1:2*SAMPLE_BITS];

  // global stage enable: move unless the output register holds an untaken item
  assign advance  = !m_tvalid || m_tready;
  // no item is taken while reset holds the valid bits clear
  assign s_tready = advance && !rst;

  fdv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_vld      (s_tvalid),
    .stick_x     (stick_x),
    .stick_y_raw (stick_y_raw),
    .heading     (heading),
    .out_vld     (front_vld),
    .out_data    (front_data)
  );

  fdv_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (iter_vld),
    .out_data (iter_data)
  );

  fdv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_vld    (iter_vld),
    .in_data   (iter_data),
    .out_vld   (m_tvalid),
    .speed     (speed_out),
    .drive_dir (wd_out)
  );

  assign m_tdata = {(OUT_W - SPEED_W - DIR_W)'(0), wd_out, speed_out};

  // stall must hold the input side
  `FDV_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "stall did not block input")
  // an untaken output item stays put
  `FDV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output item changed")
  // heading fully reduced by the end of the iteration pipeline
  `FDV_ASSERT_NOW(a_heading_reduced, iter_vld, iter_data.hu < HEAD_U_W'(FULL_TURN), "heading not reduced")
  // wrapped direction stays within half a turn
  `FDV_ASSERT_NOW(a_dir_range, m_tvalid, (wd_out >= -HALF_TURN) && (wd_out <= HALF_TURN), "direction out of range")

endmodule

`default_nettype wire
